// File: design/crlf_pkg.sv
`default_nettype none

package crlf_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_READ,
        ST_DATA
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic rx_byte;      // store or interpret one received byte
        logic req_empty;    // request that yields one empty result
        logic drain_start;  // request on a complete, non-empty line
        logic load_empty;   // load the empty result into the output register
        logic load_byte;    // load the current stored byte into the output register
        logic idx_inc;      // advance the replay index
        logic drain_end;    // clear the line state after the last byte
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic line_done;
        logic count_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: design/crlf_line_receive_buffer.sv
// CRLF-terminated line receiver.
// Slave channel: one transaction per input item. tuser[0] is the kind
// (0 = received byte in tdata, 1 = service request; tdata ignored).
// Bytes collect in a line store until CR LF completes the line; CR followed
// by anything else drops the partial line. Bytes arriving on a complete line
// are ignored.
// Master channel: one transaction per result. tdata is the line byte,
// tuser[0] marks a stored byte, tuser[1] the blink flag, tlast the final
// result of a request.
// Flow: received bytes may follow back to back. A request on a complete line
// of N bytes gives N results, each by a store read and then an output
// register load, and the slave side stays busy until the last one is loaded;
// any other request gives one empty result, and the slave side stays busy
// until it is loaded. The output register holds a result while the master side
// stalls, and the replay waits until the register frees up.
// Reset: line state, blink phase and the output register clear; the line
// store is not cleared, and only entries of the current line are replayed.
`default_nettype none

module crlf_line_receive_buffer #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0] i_s_tuser,   // [0] kind
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] line_byte
    output logic [1:0]      o_m_tuser,   // [0] byte_valid, [1] blink
    output logic            o_m_tlast
);

    import crlf_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    crlf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_kind  (i_s_tuser[0]),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    crlf_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_rx_byte  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // a request always holds off the input in the cycle after its acceptance
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser[0] == KIND_REQ)) |=> !o_s_tready)
        else $error("input accepted right after a service request");

    // an empty result is always the only and final one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("empty result without last");

    // blink only on empty results
    a_blink_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> !o_m_tuser[0])
        else $error("blink set on a stored byte");

    // control never loads both result kinds at once
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_empty && w_cmd.load_byte))
        else $error("two result loads in one cycle");

endmodule

`default_nettype wire

// File: design/crlf_ram.sv
`default_nettype none

module crlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/crlf_ctrl.sv
`default_nettype none

module crlf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_kind,
    output logic                   o_in_ready,
    input  wire crlf_pkg::t_status i_sts,
    output crlf_pkg::t_cmd         o_cmd
);

    import crlf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_kind == KIND_BYTE) begin
                        o_cmd.rx_byte = 1'b1;
                    end else if (i_sts.line_done && !i_sts.count_zero) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_READ;
                    end else begin
                        o_cmd.req_empty = 1'b1;
                        n_state         = ST_EMPTY;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_READ: begin
                // read data is registered, so it shows up in the cycle after the address
                n_state = ST_DATA;
            end
            ST_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.drain_end = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/crlf_dp.sv
`default_nettype none

module crlf_dp #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crlf_pkg::t_cmd    i_cmd,
    output crlf_pkg::t_status      o_sts,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic [1:0]             o_m_tuser,
    output logic                   o_m_tlast
);

    import crlf_pkg::*;

    localparam int CW = $clog2(LINE_DEPTH);
    localparam logic [CW-1:0] CNT_MAX = CW'(LINE_DEPTH - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_seen_cr, n_seen_cr;
    logic          r_line_done, n_line_done;
    logic          r_phase, n_phase;
    logic          r_blink_pend, n_blink_pend;
    logic [CW-1:0] r_idx, n_idx;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic          r_out_bv, n_out_bv;
    logic          r_out_last, n_out_last;
    logic          r_out_blink, n_out_blink;

    logic          w_we;
    logic [7:0]    w_rdata;
    logic          w_out_free;
    logic          w_idx_last;

    crlf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_idx_last = (r_idx == (r_count - CW'(1)));

    always_comb begin
        n_count      = r_count;
        n_seen_cr    = r_seen_cr;
        n_line_done  = r_line_done;
        n_phase      = r_phase;
        n_blink_pend = r_blink_pend;
        n_idx        = r_idx;
        w_we         = 1'b0;

        if (i_cmd.rx_byte && !r_line_done) begin
            if (r_seen_cr) begin
                if (i_rx_byte != CHAR_LF) begin
                    // CR not followed by LF: drop the partial line
                    n_count   = '0;
                    n_seen_cr = 1'b0;
                end else begin
                    n_line_done = 1'b1;
                end
            end else if (i_rx_byte == CHAR_CR) begin
                n_seen_cr = 1'b1;
            end else begin
                w_we    = 1'b1;
                n_count = (r_count == CNT_MAX) ? '0 : r_count + CW'(1);
            end
        end

        if (i_cmd.req_empty) begin
            if (r_line_done) begin
                n_count      = '0;
                n_seen_cr    = 1'b0;
                n_line_done  = 1'b0;
                n_blink_pend = 1'b0;
            end else begin
                // flag every second no-line request
                n_phase      = !r_phase;
                n_blink_pend = r_phase;
            end
        end

        if (i_cmd.drain_start) begin
            n_idx = '0;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end
        if (i_cmd.drain_end) begin
            n_count     = '0;
            n_seen_cr   = 1'b0;
            n_line_done = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_bv    = r_out_bv;
        n_out_last  = r_out_last;
        n_out_blink = r_out_blink;
        if (i_cmd.load_empty) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_bv    = 1'b0;
            n_out_last  = 1'b1;
            n_out_blink = r_blink_pend;
        end else if (i_cmd.load_byte) begin
            n_out_valid = 1'b1;
            n_out_data  = w_rdata;
            n_out_bv    = 1'b1;
            n_out_last  = w_idx_last;
            n_out_blink = 1'b0;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seen_cr   <= 1'b0;
            r_line_done <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_seen_cr   <= n_seen_cr;
            r_line_done <= n_line_done;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blink_pend <= n_blink_pend;
        r_idx        <= n_idx;
        r_out_data   <= n_out_data;
        r_out_bv     <= n_out_bv;
        r_out_last   <= n_out_last;
        r_out_blink  <= n_out_blink;
    end

    assign o_sts.line_done  = r_line_done;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.idx_last   = w_idx_last;
    assign o_sts.out_free   = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_blink, r_out_bv};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: verif/crlf_line_receive_buffer_tb.sv
`default_nettype none

module crlf_line_receive_buffer_tb;
    import crlf_pkg::*;

    localparam int LINE_DEPTH     = 64;
    localparam int CNT_W          = $clog2(LINE_DEPTH);
    localparam int RANDOM_ITEMS   = 300;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       last;
        logic       blink;
    } t_line_out;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       typed;
        t_line_out  res;
    } t_dir_row;

    localparam bit        TYPED      = 1'b1;
    localparam bit        PRED       = 1'b0;
    localparam t_line_out NO_RES     = '0;
    localparam t_line_out EMPTY_RES  = {8'h00, 1'b0, 1'b1, 1'b0};
    localparam t_line_out BLINK_RES  = {8'h00, 1'b0, 1'b1, 1'b1};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;  // [7:0] rx_byte
    logic [0:0] i_s_tuser = 1'b0;   // [0] kind
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [7:0] line_byte
    logic [1:0] o_m_tuser;          // [0] byte_valid, [1] blink
    logic       o_m_tlast;

    crlf_line_receive_buffer #(
        .LINE_DEPTH(LINE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // line receiver state as the block should hold it
    logic [7:0]       mdl_store [LINE_DEPTH];
    logic [CNT_W-1:0] mdl_count = '0;
    logic             mdl_seen_cr = 1'b0;
    logic             mdl_line_done = 1'b0;
    logic             mdl_blink = 1'b0;
    int               mdl_drains = 0;
    int               mdl_empty = 0;

    t_line_out pending_line_out [$];
    t_line_out got, want;

    int snd_idle_pct = 8;
    int rcv_idle_pct = 73;
    bit rx_hold_req = 1'b0;
    int items_accepted = 0;
    int results_checked = 0;
    int mismatch_cnt = 0;
    int stall_cycles = 0;

    t_dir_row dir_rows [23] = '{
        {KIND_REQ,  8'h00,   TYPED, EMPTY_RES},   // no line, blink phase goes odd
        {KIND_REQ,  8'hff,   TYPED, BLINK_RES},   // no line, second call flags blink
        {KIND_BYTE, CHAR_CR, PRED,  NO_RES},
        {KIND_BYTE, CHAR_LF, PRED,  NO_RES},
        {KIND_REQ,  8'h00,   TYPED, EMPTY_RES},   // empty complete line
        {KIND_BYTE, 8'h00,   PRED,  NO_RES},
        {KIND_BYTE, 8'hff,   PRED,  NO_RES},
        {KIND_BYTE, CHAR_CR, PRED,  NO_RES},
        {KIND_BYTE, CHAR_LF, PRED,  NO_RES},
        {KIND_REQ,  8'h5a,   PRED,  NO_RES},
        {KIND_BYTE, 8'h41,   PRED,  NO_RES},
        {KIND_BYTE, CHAR_CR, PRED,  NO_RES},
        {KIND_BYTE, CHAR_LF, PRED,  NO_RES},
        {KIND_BYTE, 8'h42,   PRED,  NO_RES},      // line complete: ignored
        {KIND_REQ,  8'h00,   TYPED, {8'h41, 1'b1, 1'b1, 1'b0}},
        {KIND_BYTE, 8'h78,   PRED,  NO_RES},
        {KIND_BYTE, CHAR_CR, PRED,  NO_RES},
        {KIND_BYTE, 8'h55,   PRED,  NO_RES},      // CR without LF: drop partial line
        {KIND_BYTE, 8'h79,   PRED,  NO_RES},
        {KIND_REQ,  8'h00,   TYPED, EMPTY_RES},   // partial line is kept
        {KIND_BYTE, CHAR_CR, PRED,  NO_RES},
        {KIND_BYTE, CHAR_LF, PRED,  NO_RES},
        {KIND_REQ,  8'h00,   PRED,  NO_RES}
    };

    task automatic line_rx_predict(input logic kind, input logic [7:0] data, input bit keep);
        int unsigned n;
        if (kind == KIND_BYTE) begin
            if (!mdl_line_done) begin
                if (mdl_seen_cr) begin
                    if (data != CHAR_LF) begin
                        mdl_count = '0;
                        mdl_seen_cr = 1'b0;
                    end else begin
                        mdl_line_done = 1'b1;
                    end
                end else if (data == CHAR_CR) begin
                    mdl_seen_cr = 1'b1;
                end else begin
                    mdl_store[mdl_count] = data;
                    mdl_count = (mdl_count == LINE_DEPTH - 1) ? '0 : mdl_count + 1'b1;
                end
            end
        end else if (mdl_line_done) begin
            n = mdl_count;
            mdl_count = '0;
            mdl_seen_cr = 1'b0;
            mdl_line_done = 1'b0;
            if (n == 0) begin
                mdl_empty++;
                if (keep) pending_line_out.push_back(EMPTY_RES);
            end else begin
                mdl_drains++;
                for (int unsigned i = 0; i < n; i++)
                    if (keep)
                        pending_line_out.push_back({mdl_store[i], 1'b1, i + 1 == n, 1'b0});
            end
        end else begin
            mdl_blink = ~mdl_blink;
            mdl_empty++;
            if (keep) pending_line_out.push_back({8'h00, 1'b0, 1'b1, ~mdl_blink});
        end
    endtask

    task automatic send_item(input logic kind, input logic [7:0] data,
                             input bit typed, input t_line_out typed_res);
        int gap;
        if ($urandom_range(99) < snd_idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_accepted++;
        line_rx_predict(kind, data, !typed);
        if (typed) pending_line_out.push_back(typed_res);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(KIND_BYTE, data, PRED, NO_RES);
    endtask

    task automatic send_req();
        send_item(KIND_REQ, 8'($urandom_range(255)), PRED, NO_RES);
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CHAR_CR) ? 8'h8d : b;
    endfunction

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_line_out.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_checked++;
            got = {o_m_tdata, o_m_tuser[0], o_m_tlast, o_m_tuser[1]};
            if (pending_line_out.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%02h user=%b last=%b",
                                          o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                want = pending_line_out.pop_front();
                if (got.line_byte !== want.line_byte)
                    report_mismatch($sformatf("line_byte %02h, want %02h",
                                              got.line_byte, want.line_byte));
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b",
                                              got.byte_valid, want.byte_valid));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                if (got.blink !== want.blink)
                    report_mismatch($sformatf("blink %b, want %b", got.blink, want.blink));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d results pending",
                         stall_cycles, pending_line_out.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int random_items;
        int seq_no;
        int len;
        int pick;
        int phase_now;
        int phase_prev;

        random_items = 0;
        seq_no = 0;
        phase_prev = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].kind, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].res);
        pause_until_drained();

        while (random_items < RANDOM_ITEMS) begin
            phase_now = (random_items * 3) / RANDOM_ITEMS;
            if (phase_now != phase_prev) begin
                pause_until_drained();
                phase_prev = phase_now;
            end
            case (phase_now)
                0: begin
                    snd_idle_pct = 8;
                    rcv_idle_pct = 73;
                end
                1: begin
                    snd_idle_pct = 73;
                    rcv_idle_pct = 8;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase

            seq_no++;
            pick = $urandom_range(99);
            case (seq_no)
                1: len = LINE_DEPTH;          // count wraps to zero: empty line
                2: len = LINE_DEPTH + 2;      // wraps, two bytes survive
                3: begin
                    len = 48;                 // long drain against a stalled receiver
                    rx_hold_req = 1'b1;
                end
                default: len = ($urandom_range(9) == 0) ? $urandom_range(20, LINE_DEPTH - 1)
                                                        : $urandom_range(0, 8);
            endcase

            if (seq_no <= 3 || pick < 70) begin
                repeat (len) send_byte(line_char());
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                // bytes on a complete line are ignored, not counted
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
                send_req();
                random_items += len + 3;
            end else if (pick < 85) begin
                // request without a complete line, partial bytes carried over
                len = $urandom_range(0, 3);
                repeat (len) send_byte(line_char());
                send_req();
                random_items += len + 1;
            end else begin
                // noise: raw bytes, then CR and an arbitrary follower
                len = $urandom_range(0, 4);
                repeat (len) send_byte(8'($urandom_range(255)));
                send_byte(CHAR_CR);
                send_byte(($urandom_range(3) == 0) ? CHAR_CR : 8'($urandom_range(255)));
                random_items += len + 2;
            end
        end

        pause_until_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d input items under three stall mixes and one long hold-off:",
                 items_accepted);
        $display("  %0d line drains, %0d empty results, %0d results checked, %0d mismatches",
                 mdl_drains, mdl_empty, results_checked, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/crlf_pkg.sv
design/crlf_ram.sv
design/crlf_ctrl.sv
design/crlf_dp.sv
design/crlf_line_receive_buffer.sv
verif/crlf_line_receive_buffer_tb.sv
